/* sv/lmst_pkg.sv */
package lmst_pkg;

  localparam int ANGLE_BITS_DEF = 32;

  // signed seconds from J2000 noon and its magnitude
  localparam int SECS_W = 38;
  localparam int MAG_W  = 37;
  localparam int QUAD_W = 57;

  // constants in units of 2^-64 turn (square constant 2^-128 turn), rounded to nearest
  localparam logic [191:0] BASE_WIDE =
    ((192'd28046061837 << 65) / (192'd360 * 192'd100000000) + 192'd1) >> 1;
  localparam logic [191:0] RATE_WIDE =
    ((192'd36098564736629 << 65) /
     (192'd360 * 192'd86400 * 192'd100000 * 192'd1000000) + 192'd1) >> 1;
  localparam logic [191:0] QUAD_WIDE =
    ((192'd388 << 129) /
     (192'd360 * 192'd86400 * 192'd86400 * 192'd36525 * 192'd36525 * 192'd1000000)
     + 192'd1) >> 1;

  localparam logic [63:0] BASE_C0 = BASE_WIDE[63:0];
  // rate constant stays below 2^48, split in two 24-bit halves
  localparam logic [23:0] RATE_K_LO = RATE_WIDE[23:0];
  localparam logic [23:0] RATE_K_HI = RATE_WIDE[47:24];
  // square constant stays below 2^46
  localparam logic [45:0] QUAD_Q = QUAD_WIDE[45:0];

  typedef struct packed {
    logic signed [SECS_W-1:0] secs;
    logic [MAG_W-1:0]         mag;
  } secs_t;

  typedef struct packed {
    logic [63:0]       rate;
    logic [QUAD_W-1:0] quad;
  } poly_t;

  // floor(275 * m / 9)
  function automatic logic [8:0] month_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd213;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd366;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd427;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

/* sv/lmst_secs.sv */
module lmst_secs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [11:0]           year,
  input  logic [3:0]            month,
  input  logic [4:0]            day,
  input  logic [4:0]            hour,
  input  logic [5:0]            minute,
  input  logic [5:0]            second,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lmst_pkg::secs_t       out_data
);

  logic [2:0] v_r;
  logic [2:0] rdy;

  // stage a: day number and time of day
  logic [4:0]         m9;
  logic [1:0]         mq;
  logic [12:0]        yy;
  logic [15:0]        yy7;
  logic [20:0]        t1;
  logic [8:0]         t3;
  logic signed [22:0] w_wide;
  logic signed [20:0] w_nxt, w_r;
  logic [16:0]        tod_nxt, tod_r;

  // stage b: seconds from J2000 noon
  logic signed [38:0] secs_wide;
  logic signed [lmst_pkg::SECS_W-1:0] secs_nxt, secs_b_r;

  // stage c: magnitude
  logic [lmst_pkg::SECS_W-1:0] secs_neg;
  logic [lmst_pkg::MAG_W-1:0]  mag_nxt, mag_r;
  logic signed [lmst_pkg::SECS_W-1:0] secs_c_r;

  assign rdy[2]   = !v_r[2] || out_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    m9     = {1'b0, month} + 5'd9;
    mq     = (m9 >= 5'd24) ? 2'd2 : ((m9 >= 5'd12) ? 2'd1 : 2'd0);
    yy     = {1'b0, year} + {11'b0, mq};
    yy7    = {3'b0, yy} * 16'd7;
    t1     = {9'b0, year} * 21'd367;
    t3     = lmst_pkg::month_days(month);
    w_wide = $signed({2'b0, t1}) - $signed({9'b0, yy7[15:2]}) + $signed({14'b0, t3})
             + $signed({18'b0, day}) - 23'sd730531;
    w_nxt  = $signed(w_wide[20:0]);
    tod_nxt = {12'b0, hour} * 17'd3600 + {11'b0, minute} * 17'd60 + {11'b0, second};
  end

  always_comb begin
    secs_wide = w_r * 39'sd86400 + $signed({22'b0, tod_r}) - 39'sd43200;
    secs_nxt  = $signed(secs_wide[lmst_pkg::SECS_W-1:0]);
  end

  always_comb begin
    secs_neg = -secs_b_r;
    mag_nxt  = secs_b_r[lmst_pkg::SECS_W-1] ? secs_neg[lmst_pkg::MAG_W-1:0]
                                            : secs_b_r[lmst_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      w_r   <= w_nxt;
      tod_r <= tod_nxt;
    end
    if (rdy[1] && v_r[0]) begin
      secs_b_r <= secs_nxt;
    end
    if (rdy[2] && v_r[1]) begin
      secs_c_r <= secs_b_r;
      mag_r    <= mag_nxt;
    end
  end

  assign out_valid     = v_r[2];
  assign out_data.secs = secs_c_r;
  assign out_data.mag  = mag_r;

`ifndef SYNTH
  a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && !rdy[2]) |=> (v_r[1] && $stable(secs_b_r)))
    else $error("stalled seconds stage changed");
`endif

endmodule

/* sv/lmst_poly.sv */
module lmst_poly (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lmst_pkg::secs_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lmst_pkg::poly_t  out_data
);

  logic [3:0] v_r;
  logic [3:0] rdy;

  // stage d: partial squares of the magnitude, rate partial products
  logic [17:0]        mh;
  logic [18:0]        ml;
  logic [35:0]        hh_nxt, hh_r;
  logic [36:0]        hl_nxt, hl_r;
  logic [37:0]        ll_nxt, ll_r;
  logic signed [61:0] rlo_nxt, rlo_r;
  logic signed [61:0] rhi_nxt, rhi_r;

  // stage e: full square, rate term plus base angle
  logic [73:0] sq_nxt, sq_r;
  logic [63:0] rate_e_nxt, rate_e_r;

  // stage f: square times constant in three slices
  logic [70:0] p0_nxt, p0_r;
  logic [70:0] p1_nxt, p1_r;
  logic [69:0] p2_nxt, p2_r;
  logic [63:0] rate_f_r;

  // stage g: high word of the product
  logic [120:0] sum_nxt;
  logic [lmst_pkg::QUAD_W-1:0] quad_r;
  logic [63:0] rate_g_r;

  assign rdy[3]   = !v_r[3] || out_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    mh      = in_data.mag[36:19];
    ml      = in_data.mag[18:0];
    hh_nxt  = {18'b0, mh} * {18'b0, mh};
    hl_nxt  = {19'b0, mh} * {18'b0, ml};
    ll_nxt  = {19'b0, ml} * {19'b0, ml};
    rlo_nxt = in_data.secs * $signed({1'b0, lmst_pkg::RATE_K_LO});
    rhi_nxt = in_data.secs * $signed({1'b0, lmst_pkg::RATE_K_HI});
  end

  always_comb begin
    sq_nxt     = {hh_r, 38'b0} + {17'b0, hl_r, 20'b0} + {36'b0, ll_r};
    // modulo 2^64 product of the signed seconds and the rate constant, plus the base angle
    rate_e_nxt = 64'(rlo_r) + (64'(rhi_r) << 24) + lmst_pkg::BASE_C0;
  end

  always_comb begin
    p0_nxt = {46'b0, sq_r[24:0]} * {25'b0, lmst_pkg::QUAD_Q};
    p1_nxt = {46'b0, sq_r[49:25]} * {25'b0, lmst_pkg::QUAD_Q};
    p2_nxt = {46'b0, sq_r[73:50]} * {24'b0, lmst_pkg::QUAD_Q};
  end

  always_comb begin
    sum_nxt = {50'b0, p0_r} + {25'b0, p1_r, 25'b0} + {1'b0, p2_r, 50'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      hh_r  <= hh_nxt;
      hl_r  <= hl_nxt;
      ll_r  <= ll_nxt;
      rlo_r <= rlo_nxt;
      rhi_r <= rhi_nxt;
    end
    if (rdy[1] && v_r[0]) begin
      sq_r     <= sq_nxt;
      rate_e_r <= rate_e_nxt;
    end
    if (rdy[2] && v_r[1]) begin
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      rate_f_r <= rate_e_r;
    end
    if (rdy[3] && v_r[2]) begin
      quad_r   <= sum_nxt[120:64];
      rate_g_r <= rate_f_r;
    end
  end

  assign out_valid     = v_r[3];
  assign out_data.rate = rate_g_r;
  assign out_data.quad = quad_r;

`ifndef SYNTH
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && rdy[1]) |=> v_r[1])
    else $error("product stage lost a transaction");
`endif

endmodule

/* sv/local_mean_sidereal_time_unit.sv */
// Local mean sidereal angle from a UTC calendar date and time.
// Input channel: in_valid/in_ready with year, month, day, hour, minute and
// second; one transaction per timestamp. Result channel: out_valid/out_ready
// with out_sidereal_angle, the angle as an unsigned fraction of one turn
// (top ANGLE_BITS bits of a 64-bit turn accumulator, low 32 bits kept).
// Configuration: cfg_valid/cfg_ready writes the east longitude, a fraction
// of a turn; cfg_ready is always high. Write it only while no timestamp is
// in flight.
// Throughput is one timestamp per cycle while out_ready is high. A result
// passes through these registered stages in order: three stages build the
// day count and the signed second count, four stages form the square and
// rate products, and the last stage adds the terms into the output
// register.
// Reset clears all valid bits and sets the longitude to 0. When the receiver
// holds out_ready low the result stays in the output register and upstream
// stages keep accepting until every stage is full; then in_ready drops.
module local_mean_sidereal_time_unit #(
  parameter int ANGLE_BITS = lmst_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sidereal_angle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_observer_longitude
);

  localparam int ANGLE_SHIFT = 64 - ANGLE_BITS;

  logic            secs_valid, secs_ready;
  lmst_pkg::secs_t secs_data;
  logic            poly_valid, poly_ready;
  lmst_pkg::poly_t poly_data;

  logic [31:0] lon_r;
  logic [63:0] acc;
  logic [63:0] acc_top;
  logic        out_valid_r;
  logic [31:0] out_angle_r;

  lmst_secs u_secs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .year      (in_year),
    .month     (in_month),
    .day       (in_day),
    .hour      (in_hour),
    .minute    (in_minute),
    .second    (in_second),
    .out_valid (secs_valid),
    .out_ready (secs_ready),
    .out_data  (secs_data)
  );

  lmst_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (secs_valid),
    .in_ready  (secs_ready),
    .in_data   (secs_data),
    .out_valid (poly_valid),
    .out_ready (poly_ready),
    .out_data  (poly_data)
  );

  assign cfg_ready  = 1'b1;
  assign poly_ready = !out_valid_r || out_ready;

  always_comb begin
    acc     = poly_data.rate + {7'b0, poly_data.quad} + {lon_r, 32'b0};
    acc_top = acc >> ANGLE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) lon_r <= cfg_observer_longitude;
      if (poly_ready) out_valid_r <= poly_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poly_ready && poly_valid) begin
      out_angle_r <= acc_top[31:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sidereal_angle = out_angle_r;

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input blocked while output side can move");

  a_keep_upstream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && poly_valid) |=> poly_valid)
    else $error("pending product result dropped during stall");
`endif

endmodule
